### rtl/fvo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvo_pkg
// Types and constants shared by the flow vector orientation pipeline.
// ----------------------------------------------------------------------------
package fvo_pkg;

  // Configuration register indexes.
  localparam logic CFG_RADIAN_MODE     = 1'b0;
  localparam logic CFG_CARTESIAN_FRAME = 1'b1;

  // Angle accumulator width, radians in units of 2^-28.
  localparam int ZW        = 31;
  localparam int TABLE_LEN = 24;

  // Product width of the degree scaling multiply.
  localparam int PW = ZW + 31;

  // round(2^16 * 46080 / pi)
  localparam logic signed [30:0] DEG_SCALE = 31'sd961263669;

  localparam logic signed [17:0] DEG_LIMIT = 18'sd23040;
  localparam logic signed [17:0] RAD_LIMIT = 18'sd12868;

  // atan(2^-i) * 2^28, rounded.
  localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    31'sd210828714, 31'sd124459457, 31'sd65760959, 31'sd33381290,
    31'sd16755422,  31'sd8385879,   31'sd4193963,  31'sd2097109,
    31'sd1048571,   31'sd524287,    31'sd262144,   31'sd131072,
    31'sd65536,     31'sd32768,     31'sd16384,    31'sd8192,
    31'sd4096,      31'sd2048,      31'sd1024,     31'sd512,
    31'sd256,       31'sd128,       31'sd64,       31'sd32
  };

  // Vectors whose angle is known without rotation.
  typedef enum logic [1:0] {
    SPC_NONE,
    SPC_ZERO,
    SPC_POS,
    SPC_NEG
  } spec_t;

  typedef struct packed {
    logic signed [15:0] flow_u;
    logic signed [15:0] flow_v;
    logic               row_last;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               row_last_out;
  } ang_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic  valid;
    logic  rad;
    logic  row_last;
    spec_t spec;
  } fvo_meta_t;

endpackage
`default_nettype wire

### rtl/fvo_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvo_cordic_stage
// One registered vectoring micro-rotation: drives y toward zero and
// accumulates the rotation angle.
// ----------------------------------------------------------------------------
module fvo_cordic_stage
  import fvo_pkg::*;
#(
  parameter int XW    = 35,
  parameter int SHIFT = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire fvo_meta_t              meta_d,
  input  wire logic signed [XW-1:0]   x_d,
  input  wire logic signed [XW-1:0]   y_d,
  input  wire logic signed [ZW-1:0]   z_d,
  output fvo_meta_t                   meta_q,
  output logic signed [XW-1:0]        x_q,
  output logic signed [XW-1:0]        y_q,
  output logic signed [ZW-1:0]        z_q
);

  localparam logic signed [ZW-1:0] ANGLE = ATAN_TABLE[SHIFT];

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    xs = x_d >>> SHIFT;
    ys = y_d >>> SHIFT;
    if (!y_d[XW-1]) begin
      x_next = x_d + ys;
      y_next = y_d - xs;
      z_next = z_d + ANGLE;
    end else begin
      x_next = x_d - ys;
      y_next = y_d + xs;
      z_next = z_d - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_q <= '0;
    end else if (en) begin
      meta_q <= meta_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q <= x_next;
      y_q <= y_next;
      z_q <= z_next;
    end
  end

endmodule
`default_nettype wire

### rtl/flow_vector_orientation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flow_vector_orientation
// Orientation atan(v/u) of one flow vector per pixel through a pipelined
// vectoring CORDIC, scaled to 1/256 degree or 1/8192 radian.
// ----------------------------------------------------------------------------
//  port group  | direction | handshake           | word
//  pix         | in        | pix_valid/pix_stall | flow_u, flow_v, row_last
//  ang         | out       | ang_valid/ang_stall | angle, row_last_out
//  cfg         | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word enters per cycle while ang does not stall. The pipeline has
// one sign-fold stage, one register per micro-rotation, one for the degree
// multiply and the output register. A stall on ang freezes the whole
// pipeline, which then stalls pix. Reset clears the valid bits and both
// configuration registers; the configuration is sampled as a word enters.
// ----------------------------------------------------------------------------
module flow_vector_orientation
  import fvo_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pix_valid,
  output logic      pix_stall,
  input  wire pix_t pix,
  output logic      ang_valid,
  input  wire logic ang_stall,
  output ang_t      ang,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_index,
  input  wire logic cfg_data
);

  localparam int XW   = SAMPLE_WIDTH + 19;
  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic radian_mode;
  logic cartesian_frame;
  logic en;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radian_mode     <= 1'b0;
      cartesian_frame <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIAN_MODE:     radian_mode     <= cfg_data;
        CFG_CARTESIAN_FRAME: cartesian_frame <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !ang_valid || !ang_stall;
  assign pix_stall = !en;

  // Sample extraction.
  logic signed [XW-1:0] u_in;
  logic signed [XW-1:0] v_in;

  generate
    if (SAMPLE_WIDTH <= 16) begin : g_narrow
      assign u_in = XW'(signed'(pix.flow_u[SAMPLE_WIDTH-1:0]));
      assign v_in = XW'(signed'(pix.flow_v[SAMPLE_WIDTH-1:0]));
    end else begin : g_wide
      assign u_in = XW'($unsigned(pix.flow_u));
      assign v_in = XW'($unsigned(pix.flow_v));
    end
  endgenerate

  // Fold into the right half-plane. The cartesian flip and the fold both
  // negate v, so they combine into one conditional negation.
  logic                 flip;
  logic signed [XW-1:0] u_abs;
  logic signed [XW-1:0] v_f;
  fvo_meta_t            prep_meta;

  always_comb begin
    flip  = cartesian_frame ^ u_in[XW-1];
    u_abs = u_in[XW-1] ? -u_in : u_in;
    v_f   = flip ? -v_in : v_in;
    prep_meta.valid    = pix_valid;
    prep_meta.rad      = radian_mode;
    prep_meta.row_last = pix.row_last;
    if (v_in == '0) begin
      prep_meta.spec = SPC_ZERO;
    end else if (u_in == '0) begin
      prep_meta.spec = v_f[XW-1] ? SPC_NEG : SPC_POS;
    end else begin
      prep_meta.spec = SPC_NONE;
    end
  end

  fvo_meta_t            st_meta [NSTG+1];
  logic signed [XW-1:0] st_x    [NSTG+1];
  logic signed [XW-1:0] st_y    [NSTG+1];
  logic signed [ZW-1:0] st_z    [NSTG+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_meta[0] <= '0;
    end else if (en) begin
      st_meta[0] <= prep_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_x[0] <= u_abs <<< 16;
      st_y[0] <= v_f <<< 16;
      st_z[0] <= '0;
    end
  end

  generate
    for (genvar i = 0; i < NSTG; i++) begin : g_stage
      fvo_cordic_stage #(
        .XW    (XW),
        .SHIFT (i)
      ) u_stage (
        .clk    (clk),
        .rst    (rst),
        .en     (en),
        .meta_d (st_meta[i]),
        .x_d    (st_x[i]),
        .y_d    (st_y[i]),
        .z_d    (st_z[i]),
        .meta_q (st_meta[i+1]),
        .x_q    (st_x[i+1]),
        .y_q    (st_y[i+1]),
        .z_q    (st_z[i+1])
      );
    end
  endgenerate

  // Degree scaling multiply.
  fvo_meta_t            mul_meta;
  logic signed [PW-1:0] mul_prod;
  logic signed [ZW-1:0] mul_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_meta <= '0;
    end else if (en) begin
      mul_meta <= st_meta[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_prod <= PW'(st_z[NSTG]) * PW'(DEG_SCALE);
      mul_z    <= st_z[NSTG];
    end
  end

  // Rounding, clamping and the special cases.
  logic signed [PW-1:0] deg_sum;
  logic signed [ZW:0]   rad_sum;
  logic signed [17:0]   r_raw;
  logic signed [17:0]   lim;
  logic signed [17:0]   r_fin;
  ang_t                 ang_next;

  always_comb begin
    deg_sum = mul_prod + (PW'(1) <<< 43);
    rad_sum = (ZW+1)'(mul_z) + (ZW+1)'(1 <<< 14);
    lim     = mul_meta.rad ? RAD_LIMIT : DEG_LIMIT;
    if (mul_meta.rad) begin
      r_raw = 18'(signed'(rad_sum[ZW:15]));
    end else begin
      r_raw = 18'(signed'(deg_sum[PW-1:44]));
    end
    case (mul_meta.spec)
      SPC_ZERO: r_fin = '0;
      SPC_POS:  r_fin = lim;
      SPC_NEG:  r_fin = -lim;
      default: begin
        if (r_raw > lim) begin
          r_fin = lim;
        end else if (r_raw < -lim) begin
          r_fin = -lim;
        end else begin
          r_fin = r_raw;
        end
      end
    endcase
    ang_next.angle        = r_fin[15:0];
    ang_next.row_last_out = mul_meta.row_last;
  end

  logic out_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else if (en) begin
      ang_valid <= mul_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang     <= ang_next;
      out_rad <= mul_meta.rad;
    end
  end

  // An accepted word is in the first pipeline stage in the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall |=> st_meta[0].valid)
    else $error("accepted word missing from first stage");

  // A frozen pipeline keeps its degree multiply stage unchanged.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(mul_meta) && $stable(mul_z))
    else $error("pipeline moved while frozen");

  // The angle stays within the quarter-turn limit of its unit.
  a_range: assert property (@(posedge clk) disable iff (rst)
    ang_valid |-> (out_rad && ang.angle <= 16'sd12868 && ang.angle >= -16'sd12868) ||
                  (!out_rad && ang.angle <= 16'sd23040 && ang.angle >= -16'sd23040))
    else $error("angle outside its range");

endmodule
`default_nettype wire

### dv/flow_vector_orientation_chk.sv
// ----------------------------------------------------------------------------
// flow_vector_orientation_chk
// Watches the pixel, angle and configuration channels of the orientation
// block. It keeps its own copy of the two mode bits, predicts the angle of
// every accepted pixel word with a bit-true vectoring CORDIC, and compares
// each accepted angle word with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module flow_vector_orientation_chk
  import fvo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pix_valid,
  input  wire logic pix_stall,
  input  wire pix_t pix,
  input  wire logic ang_valid,
  input  wire logic ang_stall,
  input  wire ang_t ang,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic cfg_data,
  output int        mismatches,
  output int        pending
);

  localparam int     ROTATIONS = 16;
  localparam longint DEG_MULT  = 64'sd961263669;
  localparam longint DEG_CLAMP = 64'sd23040;
  localparam longint RAD_CLAMP = 64'sd12868;

  // atan(2^-i) in radians, scaled by 2^28.
  localparam longint ROT_ANGLE [24] = '{
    64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290,
    64'sd16755422,  64'sd8385879,   64'sd4193963,  64'sd2097109,
    64'sd1048571,   64'sd524287,    64'sd262144,   64'sd131072,
    64'sd65536,     64'sd32768,     64'sd16384,    64'sd8192,
    64'sd4096,      64'sd2048,      64'sd1024,     64'sd512,
    64'sd256,       64'sd128,       64'sd64,       64'sd32
  };

  logic rad_mode;
  logic cart_frame;
  ang_t expected_angles [$];
  ang_t oldest;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic ang_t orient_pixel(input pix_t p, input logic rad, input logic cart);
    longint u, v, x, y, z, xs, ys, r, lim;
    ang_t res;
    u   = p.flow_u;
    v   = p.flow_v;
    z   = 0;
    lim = rad ? RAD_CLAMP : DEG_CLAMP;
    if (cart) v = -v;
    // Left half-plane folds onto the right one.
    if (u < 0) begin
      u = -u;
      v = -v;
    end
    if (v == 0) begin
      r = 0;
    end else if (u == 0) begin
      r = (v > 0) ? lim : -lim;
    end else begin
      x = u * 65536;
      y = v * 65536;
      for (int i = 0; i < ROTATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ROT_ANGLE[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ROT_ANGLE[i];
        end
      end
      if (rad) r = (z + (64'sd1 <<< 14)) >>> 15;
      else     r = (z * DEG_MULT + (64'sd1 <<< 43)) >>> 44;
      if (r > lim)  r = lim;
      if (r < -lim) r = -lim;
    end
    res.angle        = r[15:0];
    res.row_last_out = p.row_last;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rad_mode   = 1'b0;
      cart_frame = 1'b0;
      expected_angles.delete();
    end else begin
      if (pix_valid && !pix_stall)
        expected_angles.push_back(orient_pixel(pix, rad_mode, cart_frame));
      if (ang_valid && !ang_stall) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("angle word with no pixel pending", ang.angle, 0);
        end else begin
          oldest = expected_angles.pop_front();
          if (ang.angle !== oldest.angle)
            report_mismatch("angle", ang.angle, oldest.angle);
          if (ang.row_last_out !== oldest.row_last_out)
            report_mismatch("row_last_out", ang.row_last_out, oldest.row_last_out);
        end
      end
      // A mode write only affects words that enter after it.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIAN_MODE:     rad_mode   = cfg_data;
          CFG_CARTESIAN_FRAME: cart_frame = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_angles.size();
  end

endmodule

### dv/flow_vector_orientation_tb.sv
// ----------------------------------------------------------------------------
// flow_vector_orientation_tb
// Drives the orientation block with corner vectors and then random flow
// vectors under four mode settings, with random gaps on the pixel side and
// random backpressure on the angle side. The checker beside the block does
// the prediction and comparison; this module makes stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module flow_vector_orientation_tb;
  import fvo_pkg::*;

  localparam int RANDOM_PER_PHASE = 240;
  localparam int SETTLE_CYCLES    = 24;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pix_t pix       = '0;
  logic ang_valid;
  logic ang_stall = 1'b0;
  ang_t ang;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic cfg_data  = 1'b0;
  int   mismatches;
  int   pending;
  logic quiet     = 1'b0;

  // Vectors on the axes, at the range limits and on the diagonals.
  pix_t corner_words [23] = '{
    '{16'sd0,      16'sd0,      1'b0},
    '{16'sd0,      16'sd256,    1'b0},
    '{16'sd0,     -16'sd256,    1'b1},
    '{16'sd0,      16'sh8000,   1'b0},
    '{16'sd0,      16'sd32767,  1'b0},
    '{16'sd1000,   16'sd0,      1'b0},
    '{16'sh8000,   16'sd0,      1'b1},
    '{16'sd32767,  16'sd32767,  1'b0},
    '{16'sh8000,   16'sh8000,   1'b0},
    '{16'sh8000,   16'sd32767,  1'b0},
    '{16'sd32767,  16'sh8000,   1'b1},
    '{16'sh8000,   16'sd1,      1'b0},
    '{16'sd1,      16'sh8000,   1'b0},
    '{16'sd1,      16'sd32767,  1'b0},
    '{16'sd32767,  16'sd1,      1'b0},
    '{-16'sd1,     16'sd1,      1'b0},
    '{16'sd1,     -16'sd1,      1'b0},
    '{-16'sd1,    -16'sd1,      1'b1},
    '{16'sd256,    16'sd256,    1'b0},
    '{-16'sd256,   16'sd256,    1'b0},
    '{16'sd443,    16'sd256,    1'b0},
    '{16'sd256,   -16'sd443,    1'b1},
    '{-16'sd3,    -16'sd7,      1'b0}
  };

  flow_vector_orientation DUT (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .ang_valid (ang_valid),
    .ang_stall (ang_stall),
    .ang       (ang),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flow_vector_orientation_chk orient_chk (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix),
    .ang_valid  (ang_valid),
    .ang_stall  (ang_stall),
    .ang        (ang),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short idle spans, now and then a long one.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sd32767;
          2: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Valid stays high into the next word when no gap follows.
  task automatic send_pixel(input pix_t w);
    int gap;
    pix       <= w;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    gap = quiet ? 0 : gap_length();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : ang_backpressure
    int hold;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        ang_stall <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        hold = gap_length();
        if (hold > 0) begin
          ang_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        ang_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin : pixel_source
    logic [1:0] modes [5];
    pix_t w;
    modes = '{2'b00, 2'b01, 2'b11, 2'b10, 2'b00};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first phase runs on the reset values of both mode bits.
    foreach (corner_words[k]) send_pixel(corner_words[k]);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain_pipeline();
        write_reg(CFG_RADIAN_MODE, modes[ph][0]);
        write_reg(CFG_CARTESIAN_FRAME, modes[ph][1]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) quiet <= ($urandom_range(0, 3) == 0);
        w.flow_u   = random_sample();
        w.flow_v   = random_sample();
        w.row_last = ($urandom_range(0, 7) == 0);
        send_pixel(w);
      end
    end
    drain_pipeline();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
